>>> hw/rtl/mbps_pkg.sv
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int ADDRESS_BITS      = 48;
    localparam int OUT_ADDR_BITS     = 48;
    localparam int LEN_BITS          = 5;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CARE_BITS         = 16;
    localparam int RQ_DEPTH          = 4;
    localparam int RQ_PTR_BITS       = 2;
    localparam int RQ_CNT_BITS       = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_REGION_BASE  = 3'd4,
        REG_FIND_ALL     = 3'd5
    } t_cfg_reg;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] t_window;

    typedef struct packed {
        logic [OUT_ADDR_BITS-1:0] match_address;
        logic                     found;
        logic                     scan_done;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res_a;
        t_result    res_b;
    } t_push;

endpackage

>>> hw/rtl/mbps_in_if.sv
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/mbps_out_if.sv
interface mbps_out_if;
    logic                              valid;
    logic                              ready;
    logic [mbps_pkg::OUT_ADDR_BITS-1:0] match_address;
    logic                              found;
    logic                              scan_done;

    modport source (output valid, output match_address, output found, output scan_done,
                    input ready);
    modport sink (input valid, input match_address, input found, input scan_done,
                  output ready);
endinterface

>>> hw/rtl/mbps_match.sv
module mbps_match (
    input  mbps_pkg::t_window                  i_window,
    input  mbps_pkg::t_window                  i_pattern,
    input  logic [mbps_pkg::CARE_BITS-1:0]     i_care_mask,
    input  logic [mbps_pkg::LEN_BITS-1:0]      i_len,
    output logic                               o_match
);

    logic [mbps_pkg::MAX_PATTERN_BYTES-1:0] w_lane_ok;

    // Lane i holds the byte received i requests ago; it lines up with
    // pattern byte len-1-i.
    always_comb begin
        logic [3:0] pidx;
        logic       in_win;
        for (int i = 0; i < mbps_pkg::MAX_PATTERN_BYTES; i++) begin
            in_win       = mbps_pkg::LEN_BITS'(i) < i_len;
            pidx         = 4'(i_len - mbps_pkg::LEN_BITS'(i) - mbps_pkg::LEN_BITS'(1));
            w_lane_ok[i] = !in_win || !i_care_mask[pidx] || (i_window[i] == i_pattern[pidx]);
        end
    end

    assign o_match = &w_lane_ok;

endmodule

>>> hw/rtl/mbps_rq.sv
module mbps_rq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbps_pkg::t_push   i_push,
    input  logic              i_pop,
    output mbps_pkg::t_result o_head,
    output logic              o_valid,
    output logic              o_ready
);

    mbps_pkg::t_result                  r_mem [mbps_pkg::RQ_DEPTH];
    logic [mbps_pkg::RQ_PTR_BITS-1:0]   r_wr_ptr;
    logic [mbps_pkg::RQ_PTR_BITS-1:0]   r_rd_ptr;
    logic [mbps_pkg::RQ_CNT_BITS-1:0]   r_count;
    logic [mbps_pkg::RQ_CNT_BITS-1:0]   n_count;

    assign n_count = r_count + mbps_pkg::RQ_CNT_BITS'(i_push.count)
                     - mbps_pkg::RQ_CNT_BITS'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res_a;
        end
        if (i_push.count == 2'd2) begin
            r_mem[mbps_pkg::RQ_PTR_BITS'(r_wr_ptr + 1'b1)] <= i_push.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= mbps_pkg::RQ_PTR_BITS'(r_wr_ptr + mbps_pkg::RQ_PTR_BITS'(i_push.count));
            r_rd_ptr <= mbps_pkg::RQ_PTR_BITS'(r_rd_ptr + mbps_pkg::RQ_PTR_BITS'(i_pop));
            r_count  <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = r_count != '0;
    // Room for the two results that one request can cause.
    assign o_ready = r_count <= mbps_pkg::RQ_CNT_BITS'(mbps_pkg::RQ_DEPTH - 2);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (4'(r_count) + 4'(i_push.count) - 4'(i_pop)) <= 4'(mbps_pkg::RQ_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("result queue underflow");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count == 2'd0 && !i_pop) |=> $stable(r_count))
        else $error("result count moved without traffic");

endmodule

>>> hw/rtl/masked_byte_pattern_scanner.sv
// Results of accepted requests are queued in registers and offered in order.
// Throughput: one request per cycle while results drain; a four-entry result queue
// accepts a request whenever it has room for two results.
// Reset is synchronous and active low: configuration returns to its reset values,
// the byte window, offset and first-match flag clear, and the result queue empties.
module masked_byte_pattern_scanner (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mbps_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    mbps_in_if.sink                               i_in,
    mbps_out_if.source                            o_out
);

    logic [63:0]                          r_pat_low;
    logic [63:0]                          r_pat_high;
    logic [mbps_pkg::CARE_BITS-1:0]       r_care;
    logic [mbps_pkg::LEN_BITS-1:0]        r_len;
    logic [mbps_pkg::OUT_ADDR_BITS-1:0]   r_base;
    logic                                 r_find_all;

    mbps_pkg::t_window                    r_window;
    logic [mbps_pkg::ADDRESS_BITS-1:0]    r_offset;
    logic                                 r_first_found;

    mbps_pkg::t_window                    n_window;
    logic [mbps_pkg::ADDRESS_BITS-1:0]    n_offset;
    logic                                 n_first_found;

    mbps_pkg::t_window                    w_window;
    mbps_pkg::t_window                    w_pattern;
    logic [mbps_pkg::LEN_BITS-1:0]        w_len;
    logic [mbps_pkg::ADDRESS_BITS-1:0]    w_count;
    logic [mbps_pkg::ADDRESS_BITS-1:0]    w_addr;
    logic                                 w_match;
    logic                                 w_hit;
    logic                                 w_end;
    logic                                 w_acc;
    mbps_pkg::t_push                      w_push;
    mbps_pkg::t_result                    w_head;
    logic                                 w_rq_valid;
    logic                                 w_rq_ready;
    mbps_pkg::t_result                    w_match_res;
    mbps_pkg::t_result                    w_end_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_care     <= '0;
            r_len      <= mbps_pkg::LEN_BITS'(1);
            r_base     <= '0;
            r_find_all <= 1'b0;
        end else if (i_cfg_we) begin
            case (mbps_pkg::t_cfg_reg'(i_cfg_index))
                mbps_pkg::REG_PATTERN_LOW: begin
                    r_pat_low <= i_cfg_data[63:0];
                end
                mbps_pkg::REG_PATTERN_HIGH: begin
                    r_pat_high <= i_cfg_data[63:0];
                end
                mbps_pkg::REG_CARE_MASK: begin
                    r_care <= i_cfg_data[mbps_pkg::CARE_BITS-1:0];
                end
                mbps_pkg::REG_PATTERN_LEN: begin
                    r_len <= i_cfg_data[mbps_pkg::LEN_BITS-1:0];
                end
                mbps_pkg::REG_REGION_BASE: begin
                    r_base <= i_cfg_data[mbps_pkg::OUT_ADDR_BITS-1:0];
                end
                mbps_pkg::REG_FIND_ALL: begin
                    r_find_all <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_len == '0) begin
            w_len = mbps_pkg::LEN_BITS'(1);
        end else if (r_len > mbps_pkg::LEN_BITS'(mbps_pkg::MAX_PATTERN_BYTES)) begin
            w_len = mbps_pkg::LEN_BITS'(mbps_pkg::MAX_PATTERN_BYTES);
        end else begin
            w_len = r_len;
        end
    end

    assign w_pattern = {r_pat_high, r_pat_low};
    assign w_window  = {r_window[mbps_pkg::MAX_PATTERN_BYTES-2:0], i_in.data_byte};
    assign w_count   = r_offset + mbps_pkg::ADDRESS_BITS'(1);
    assign w_addr    = mbps_pkg::ADDRESS_BITS'(r_base) + w_count
                       - mbps_pkg::ADDRESS_BITS'(w_len);

    mbps_match u_match (
        .i_window    (w_window),
        .i_pattern   (w_pattern),
        .i_care_mask (r_care),
        .i_len       (w_len),
        .o_match     (w_match)
    );

    assign w_acc = i_in.valid && i_in.ready;
    assign w_hit = (r_find_all || !r_first_found)
                   && (w_count >= mbps_pkg::ADDRESS_BITS'(w_len)) && w_match;
    assign w_end = i_in.last_byte && (r_find_all || !(r_first_found || w_hit));

    assign w_match_res = '{match_address: w_addr[mbps_pkg::OUT_ADDR_BITS-1:0],
                           found: 1'b1, scan_done: !r_find_all};
    assign w_end_res   = '{match_address: '0, found: 1'b0, scan_done: 1'b1};

    always_comb begin
        w_push.count = w_acc ? (2'(w_hit) + 2'(w_end)) : 2'd0;
        w_push.res_a = w_hit ? w_match_res : w_end_res;
        w_push.res_b = w_end_res;
    end

    always_comb begin
        if (i_in.last_byte) begin
            n_window      = '0;
            n_offset      = '0;
            n_first_found = 1'b0;
        end else begin
            n_window      = w_window;
            n_offset      = w_count;
            n_first_found = r_first_found || (w_hit && !r_find_all);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= '0;
            r_offset      <= '0;
            r_first_found <= 1'b0;
        end else if (w_acc) begin
            r_window      <= n_window;
            r_offset      <= n_offset;
            r_first_found <= n_first_found;
        end
    end

    mbps_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (o_out.valid && o_out.ready),
        .o_head  (w_head),
        .o_valid (w_rq_valid),
        .o_ready (w_rq_ready)
    );

    assign i_in.ready          = w_rq_ready;
    assign o_out.valid         = w_rq_valid;
    assign o_out.match_address = w_head.match_address;
    assign o_out.found         = w_head.found;
    assign o_out.scan_done     = w_head.scan_done;

    a_region_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.last_byte) |=> (r_offset == '0 && !r_first_found))
        else $error("region state not cleared after final byte");

    a_two_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count == 2'd2) |-> (r_find_all && i_in.last_byte))
        else $error("two results outside an all-mode region end");

    a_first_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_hit && !r_find_all) |-> !r_first_found)
        else $error("second match reported in first mode");

endmodule

>>> tb/mbps_scan_checker.sv
`timescale 1ns / 100ps
module mbps_scan_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbps_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    mbps_in_if                                  i_in_ch,
    mbps_out_if                                 i_out_ch,
    output int                                  o_errors,
    output int                                  o_pending
);

    logic [63:0]                         pattern_low;
    logic [63:0]                         pattern_high;
    logic [mbps_pkg::CARE_BITS-1:0]      care_mask;
    logic [mbps_pkg::LEN_BITS-1:0]       length_code;
    logic [mbps_pkg::ADDRESS_BITS-1:0]   base_addr;
    logic                                all_matches;

    mbps_pkg::t_window                   window;
    logic [mbps_pkg::ADDRESS_BITS-1:0]   bytes_seen;
    logic                                first_hit;

    mbps_pkg::t_result                   expected_results[$];
    int                                  mismatches = 0;

    assign o_errors = mismatches;

    task automatic clear_region();
        window     = '0;
        bytes_seen = '0;
        first_hit  = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] value, input logic last);
        int unsigned                       span;
        int unsigned                       j;
        logic [mbps_pkg::ADDRESS_BITS-1:0] count;
        logic [mbps_pkg::ADDRESS_BITS-1:0] addr;
        logic [7:0]                        want;
        bit                                hit;
        mbps_pkg::t_result                 res;
        span = (length_code == 0) ? 1 :
               (length_code > mbps_pkg::MAX_PATTERN_BYTES) ?
               mbps_pkg::MAX_PATTERN_BYTES : length_code;
        window = {window[mbps_pkg::MAX_PATTERN_BYTES-2:0], value};
        count  = bytes_seen + 1'b1;
        hit    = (count >= span);
        for (j = 0; j < span; j++) begin
            if (j < 8) begin
                want = pattern_low[8*j +: 8];
            end else begin
                want = pattern_high[8*(j-8) +: 8];
            end
            if (care_mask[j] && window[span-1-j] != want) begin
                hit = 1'b0;
            end
        end
        if ((all_matches || !first_hit) && hit) begin
            addr              = base_addr + count - mbps_pkg::ADDRESS_BITS'(span);
            res.match_address = addr;
            res.found         = 1'b1;
            res.scan_done     = !all_matches;
            expected_results.insert(expected_results.size(), res);
            if (!all_matches) begin
                first_hit = 1'b1;
            end
        end
        if (last) begin
            if (all_matches || !first_hit) begin
                res.match_address = '0;
                res.found         = 1'b0;
                res.scan_done     = 1'b1;
                expected_results.insert(expected_results.size(), res);
            end
            clear_region();
        end else begin
            bytes_seen = count;
        end
    endtask

    always @(posedge i_clk) begin : watch
        mbps_pkg::t_result oldest;
        if (!i_rst_n) begin
            pattern_low  = '0;
            pattern_high = '0;
            care_mask    = '0;
            length_code  = mbps_pkg::LEN_BITS'(1);
            base_addr    = '0;
            all_matches  = 1'b0;
            clear_region();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mbps_pkg::REG_PATTERN_LOW:  pattern_low  = i_cfg_data;
                    mbps_pkg::REG_PATTERN_HIGH: pattern_high = i_cfg_data;
                    mbps_pkg::REG_CARE_MASK:
                        care_mask = i_cfg_data[mbps_pkg::CARE_BITS-1:0];
                    mbps_pkg::REG_PATTERN_LEN:
                        length_code = i_cfg_data[mbps_pkg::LEN_BITS-1:0];
                    mbps_pkg::REG_REGION_BASE:
                        base_addr = i_cfg_data[mbps_pkg::ADDRESS_BITS-1:0];
                    mbps_pkg::REG_FIND_ALL:     all_matches  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                scan_byte(i_in_ch.data_byte, i_in_ch.last_byte);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error({"result with no request outstanding: ",
                            "match_address %h found %b scan_done %b"},
                           i_out_ch.match_address, i_out_ch.found, i_out_ch.scan_done);
                    mismatches++;
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_out_ch.match_address !== oldest.match_address) begin
                        $error("match_address: expected %h, actual %h",
                               oldest.match_address, i_out_ch.match_address);
                        mismatches++;
                    end
                    if (i_out_ch.found !== oldest.found) begin
                        $error("found: expected %b, actual %b", oldest.found, i_out_ch.found);
                        mismatches++;
                    end
                    if (i_out_ch.scan_done !== oldest.scan_done) begin
                        $error("scan_done: expected %b, actual %b",
                               oldest.scan_done, i_out_ch.scan_done);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
module tb;

    localparam int ITEM_TARGET      = 1500;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 4;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int MAX_REGION       = 64;
    localparam logic [mbps_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [mbps_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;
    localparam logic [mbps_pkg::ADDRESS_BITS-1:0]   ADDR_MAX    = '1;

    typedef enum int {SINK_FLOW, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} t_sink_mode;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [mbps_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [mbps_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    mbps_in_if  in_ch();
    mbps_out_if out_ch();

    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   burst_left  = 0;
    bit   gaps_on     = 1'b1;
    bit   hold_req;

    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] care_bits;
    int          pat_len;

    masked_byte_pattern_scanner uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    mbps_scan_checker match_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_ch     (in_ch),
        .i_out_ch    (out_ch),
        .o_errors    (error_count),
        .o_pending   (pending_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] pattern_byte(input int j);
        if (j < 8) begin
            return pat_lo[8*j +: 8];
        end
        return pat_hi[8*(j-8) +: 8];
    endfunction

    task automatic write_reg(input logic [mbps_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic program_scan(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [15:0] mask, input logic [4:0] len_code,
                                input logic [47:0] base, input logic all);
        write_reg(mbps_pkg::REG_PATTERN_LOW, lo);
        write_reg(mbps_pkg::REG_PATTERN_HIGH, hi);
        write_reg(mbps_pkg::REG_CARE_MASK, {$urandom, 16'($urandom), mask});
        write_reg(mbps_pkg::REG_PATTERN_LEN, {$urandom, 27'($urandom), len_code});
        write_reg(mbps_pkg::REG_REGION_BASE, {16'($urandom), base});
        write_reg(mbps_pkg::REG_FIND_ALL, {$urandom, 31'($urandom), all});
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
        i_cfg_we  <= 1'b0;
        pat_lo    = lo;
        pat_hi    = hi;
        care_bits = mask;
        pat_len   = (len_code == 0) ? 1 : (len_code > 16) ? 16 : len_code;
    endtask

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= value;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Most regions carry planted copies of the pattern with random wildcard bytes.
    task automatic send_region(input int len, input bit terminate);
        logic [7:0] region_bytes[MAX_REGION];
        bit         near_miss;
        int         pos;
        int         i;
        int         j;
        near_miss = ($urandom_range(0, 2) == 0);
        for (i = 0; i < len; i++) begin
            region_bytes[i] = near_miss ? pattern_byte($urandom_range(0, pat_len - 1))
                                        : 8'($urandom);
        end
        if (len >= pat_len && $urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 3)) begin
                pos = $urandom_range(0, len - pat_len);
                for (j = 0; j < pat_len; j++) begin
                    if (care_bits[j]) begin
                        region_bytes[pos+j] = pattern_byte(j);
                    end
                end
            end
        end
        for (i = 0; i < len; i++) begin
            send_byte(region_bytes[i], terminate && i == len - 1);
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int region_length();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            return $urandom_range(1, 24);
        end
        return $urandom_range(25, MAX_REGION);
    endfunction

    initial begin : receiver
        t_sink_mode mode;
        int         stretch;
        bit         held;
        out_ch.ready = 1'b0;
        mode         = SINK_FLOW;
        stretch      = 0;
        held         = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end
            if (stretch == 0) begin
                mode    = t_sink_mode'($urandom_range(0, 3));
                stretch = $urandom_range(10, 60);
            end
            stretch--;
            case (mode)
                SINK_FLOW:   out_ch.ready <= 1'b1;
                SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 2) == 0);
                default:     out_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial begin : stimulus
        logic [4:0]  len_code;
        logic [15:0] mask;
        logic [47:0] base;
        int          i;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = mbps_pkg::REG_PATTERN_LOW;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        hold_req        = 1'b0;
        pat_lo          = '0;
        pat_hi          = '0;
        care_bits       = '0;
        pat_len         = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default setup after reset: first mode, one wildcard byte, so the first byte hits.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        settle();

        // Zero length acts as one; the match address wraps past the top of the space.
        program_scan(64'hFF, 64'h0, 16'h0001, 5'd0, ADDR_MAX, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // Oversized length saturates to the full window; only both end bytes are checked.
        program_scan({$urandom, 24'($urandom), 8'hFF}, {8'hA5, 24'($urandom), $urandom},
                     16'h8001, 5'd17, 48'h0000_1234_5678, 1'b0);
        send_byte(8'hFF, 1'b0);
        for (i = 0; i < 14; i++) begin
            send_byte(8'($urandom), 1'b0);
        end
        send_byte(8'hA5, 1'b1);
        // A region shorter than the pattern gives only the end result.
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
        settle();

        // Every byte matches in all mode, so the result queue fills while the sink holds off.
        program_scan({$urandom, $urandom}, {$urandom, $urandom}, 16'h0, 5'd1,
                     48'($urandom), 1'b1);
        gaps_on  = 1'b0;
        hold_req <= 1'b1;
        repeat (4) send_region($urandom_range(8, 16), 1'b1);
        settle();

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 6))
                0:       len_code = 5'd0;
                1:       len_code = 5'd1;
                2:       len_code = 5'd16;
                3:       len_code = 5'($urandom_range(17, 31));
                default: len_code = 5'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 3))
                0:       mask = 16'h0000;
                1:       mask = 16'hFFFF;
                2:       mask = 16'($urandom);
                default: mask = 16'($urandom) & 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = ADDR_MAX;
                2:       base = ADDR_MAX - 48'($urandom_range(0, 40));
                default: base = {16'($urandom), $urandom};
            endcase
            program_scan({$urandom, $urandom}, {$urandom, $urandom}, mask, len_code, base,
                         1'($urandom_range(0, 1)));
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 8)) send_region(region_length(), 1'b1);
            if ($urandom_range(0, 4) == 0) begin
                send_region($urandom_range(1, 8), 1'b0);
            end
            settle();
        end

        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_in_if.sv
hw/rtl/mbps_out_if.sv
hw/rtl/mbps_match.sv
hw/rtl/mbps_rq.sv
hw/rtl/masked_byte_pattern_scanner.sv
tb/mbps_scan_checker.sv
tb/tb.sv
